// ===== rtl/core/tddp_pkg.sv =====
// ----------------------------------------------------------------------------
// Timestamp delta-of-delta packer package
// Shared request, response and stage types, command codes and code prefixes.
// ----------------------------------------------------------------------------
package tddp_pkg;

   // Command codes carried in a request.
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_NEXT  = 2'd1;
   localparam logic [1:0] CMD_CLOSE = 2'd2;

   // Widths of the bit stream and of the staged code.
   localparam int WORD_W = 64;
   localparam int CODE_W = 128;
   localparam int NBITS_W = 7;

   // Prefixes of the variable-length delta-of-delta codes.
   localparam logic [1:0] PFX_SHORT  = 2'b10;
   localparam logic [2:0] PFX_MEDIUM = 3'b110;
   localparam logic [3:0] PFX_LONG   = 4'b1110;
   localparam logic [3:0] PFX_ESCAPE = 4'b1111;

   // Total code lengths in bits.
   localparam logic [NBITS_W-1:0] LEN_ZERO   = 7'd1;
   localparam logic [NBITS_W-1:0] LEN_SHORT  = 7'd9;
   localparam logic [NBITS_W-1:0] LEN_MEDIUM = 7'd12;
   localparam logic [NBITS_W-1:0] LEN_LONG   = 7'd16;
   localparam logic [NBITS_W-1:0] LEN_ESCAPE = 7'd36;
   localparam logic [NBITS_W-1:0] LEN_START  = 7'd64;
   localparam logic [NBITS_W-1:0] LEN_CLOSE  = 7'd100;

   // Response queue geometry.
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = 3;
   localparam int CNT_W      = 4;
   localparam int MAX_PUSH   = 3;

   typedef struct packed {
      logic [1:0]        command;
      logic [WORD_W-1:0] timestamp;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] packed_word;
      logic              last;
      logic              truncated;
   } rsp_type;

   // One encoded item: code bits left aligned, zero below its length.
   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [NBITS_W-1:0] nbits;
      logic               close;
      logic               trunc;
   } enc_type;

endpackage

// ===== rtl/core/tddp_encoder.sv =====
// ----------------------------------------------------------------------------
// Delta-of-delta encoder
// Registers each request as a left-aligned code with its length.
// ----------------------------------------------------------------------------
module tddp_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tddp_pkg::req_type req_data,
   output logic              enc_valid,
   output tddp_pkg::enc_type enc_data,
   input  logic              enc_take
);

   logic                         valid_ff;
   logic                         valid_in;
   tddp_pkg::enc_type            enc_ff;
   tddp_pkg::enc_type            enc_in;
   logic [tddp_pkg::WORD_W-1:0]  prev_ts_ff;
   logic [tddp_pkg::WORD_W-1:0]  prev_ts_in;
   logic [tddp_pkg::WORD_W-1:0]  prev_delta_ff;
   logic [tddp_pkg::WORD_W-1:0]  prev_delta_in;
   logic [tddp_pkg::WORD_W-1:0]  delta;
   logic [tddp_pkg::WORD_W-1:0]  dod;
   logic [tddp_pkg::WORD_W-1:0]  zz;
   logic                         accept;

   // The stage is free when empty or when the packer takes its item.
   assign req_ready = !valid_ff || enc_take;
   assign accept    = req_valid && req_ready;

   // Delta, delta-of-delta and zigzag mapping.
   assign delta = req_data.timestamp - prev_ts_ff;
   assign dod   = delta - prev_delta_ff;
   assign zz    = {dod[tddp_pkg::WORD_W-2:0], 1'b0} ^ {tddp_pkg::WORD_W{dod[tddp_pkg::WORD_W-1]}};

   // Select the code for the request.
   always_comb begin
      enc_in        = '0;
      prev_ts_in    = prev_ts_ff;
      prev_delta_in = prev_delta_ff;
      case (req_data.command)
         tddp_pkg::CMD_START: begin
            enc_in.code   = {req_data.timestamp, 64'd0};
            enc_in.nbits  = tddp_pkg::LEN_START;
            prev_ts_in    = req_data.timestamp;
            prev_delta_in = '0;
         end
         tddp_pkg::CMD_NEXT: begin
            if (dod == '0) begin
               enc_in.code  = '0;
               enc_in.nbits = tddp_pkg::LEN_ZERO;
            end else if (zz[63:7] == '0) begin
               enc_in.code  = {tddp_pkg::PFX_SHORT, zz[6:0], 119'd0};
               enc_in.nbits = tddp_pkg::LEN_SHORT;
            end else if (zz[63:9] == '0) begin
               enc_in.code  = {tddp_pkg::PFX_MEDIUM, zz[8:0], 116'd0};
               enc_in.nbits = tddp_pkg::LEN_MEDIUM;
            end else if (zz[63:12] == '0) begin
               enc_in.code  = {tddp_pkg::PFX_LONG, zz[11:0], 112'd0};
               enc_in.nbits = tddp_pkg::LEN_LONG;
            end else begin
               enc_in.code  = {tddp_pkg::PFX_ESCAPE, zz[31:0], 92'd0};
               enc_in.nbits = tddp_pkg::LEN_ESCAPE;
               enc_in.trunc = zz[63:32] != '0;
            end
            prev_ts_in    = req_data.timestamp;
            prev_delta_in = delta;
         end
         tddp_pkg::CMD_CLOSE: begin
            enc_in.code  = {tddp_pkg::PFX_ESCAPE, 32'hFFFF_FFFF, 92'd0};
            enc_in.nbits = tddp_pkg::LEN_CLOSE;
            enc_in.close = 1'b1;
         end
         default: begin
            // An unused command passes as an empty code.
            enc_in = '0;
         end
      endcase
   end

   // Stage valid follows accept and take.
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (enc_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Control and history registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         prev_ts_ff    <= '0;
         prev_delta_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            prev_ts_ff    <= prev_ts_in;
            prev_delta_ff <= prev_delta_in;
         end
      end
   end

   // Staged code.
   always_ff @(posedge clock) begin
      if (accept) begin
         enc_ff <= enc_in;
      end
   end

   assign enc_valid = valid_ff;
   assign enc_data  = enc_ff;

endmodule

// ===== rtl/core/tddp_packer.sv =====
// ----------------------------------------------------------------------------
// Bit packer
// Appends each code to the pending bits and hands out completed words.
// ----------------------------------------------------------------------------
module tddp_packer (
   input  logic              clock,
   input  logic              reset,
   input  logic              enc_valid,
   input  tddp_pkg::enc_type enc_data,
   output logic              enc_take,
   input  logic              space_ok,
   output logic [1:0]        push_cnt,
   output tddp_pkg::rsp_type push_data [tddp_pkg::MAX_PUSH]
);

   // Pending bits are kept left aligned with zeros below the fill.
   logic [tddp_pkg::WORD_W-1:0] buf_ff;
   logic [tddp_pkg::WORD_W-1:0] buf_in;
   logic [5:0]                  fill_ff;
   logic [5:0]                  fill_in;
   logic [191:0]                stream;
   logic [7:0]                  total;
   logic [1:0]                  nfull;
   logic [5:0]                  rem;
   logic [1:0]                  nwords;
   logic [tddp_pkg::WORD_W-1:0] slice [tddp_pkg::MAX_PUSH];

   assign enc_take = enc_valid && space_ok;

   // Join pending bits and the new code into one window.
   assign stream = {buf_ff, 128'd0} | ({enc_data.code, 64'd0} >> fill_ff);
   assign total  = {2'b00, fill_ff} + {1'b0, enc_data.nbits};
   assign nfull  = total[7:6];
   assign rem    = total[5:0];

   assign slice[0] = stream[191:128];
   assign slice[1] = stream[127:64];
   assign slice[2] = stream[63:0];

   // A close also flushes the partial word.
   assign nwords = (enc_data.close && rem != '0) ? nfull + 2'd1 : nfull;

   // Words handed to the response queue.
   always_comb begin
      for (int i = 0; i < tddp_pkg::MAX_PUSH; i++) begin
         push_data[i].packed_word = slice[i];
         push_data[i].last        = 2'(i) == nwords - 2'd1;
         push_data[i].truncated   = enc_data.trunc;
      end
      push_cnt = enc_take ? nwords : 2'd0;
   end

   // Leftover bits after the completed words.
   always_comb begin
      if (enc_data.close) begin
         buf_in  = '0;
         fill_in = '0;
      end else begin
         fill_in = rem;
         case (nfull)
            2'd0:    buf_in = slice[0];
            2'd1:    buf_in = slice[1];
            default: buf_in = slice[2];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= '0;
         fill_ff <= '0;
      end else if (enc_take) begin
         buf_ff  <= buf_in;
         fill_ff <= fill_in;
      end
   end

   // A close leaves the buffer empty.
   a_close_empties: assert property (@(posedge clock) disable iff (reset)
      enc_take && enc_data.close |=> fill_ff == '0 && buf_ff == '0)
      else $error("close left pending bits");

endmodule

// ===== rtl/core/tddp_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// Response queue
// Takes up to three words a cycle and sends one a cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module tddp_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_cnt,
   input  tddp_pkg::rsp_type push_data [tddp_pkg::MAX_PUSH],
   output logic              space_ok,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tddp_pkg::rsp_type rsp_data
);

   tddp_pkg::rsp_type                mem [tddp_pkg::FIFO_DEPTH];
   logic [tddp_pkg::PTR_W-1:0]       wr_ptr_ff;
   logic [tddp_pkg::PTR_W-1:0]       wr_ptr_in;
   logic [tddp_pkg::PTR_W-1:0]       rd_ptr_ff;
   logic [tddp_pkg::PTR_W-1:0]       rd_ptr_in;
   logic [tddp_pkg::CNT_W-1:0]       count_ff;
   logic [tddp_pkg::CNT_W-1:0]       count_in;
   logic                             pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem[rd_ptr_ff];
   // Room for the largest burst one request can cause.
   assign space_ok  = count_ff <= tddp_pkg::CNT_W'(tddp_pkg::FIFO_DEPTH - tddp_pkg::MAX_PUSH);

   assign wr_ptr_in = wr_ptr_ff + tddp_pkg::PTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + tddp_pkg::PTR_W'(pop);
   assign count_in  = count_ff + tddp_pkg::CNT_W'(push_cnt) - tddp_pkg::CNT_W'(pop);

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, written at consecutive entries.
   always_ff @(posedge clock) begin
      for (int i = 0; i < tddp_pkg::MAX_PUSH; i++) begin
         if (2'(i) < push_cnt) begin
            mem[wr_ptr_ff + tddp_pkg::PTR_W'(i)] <= push_data[i];
         end
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tddp_pkg::CNT_W'(tddp_pkg::FIFO_DEPTH))
      else $error("response queue over depth");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd0 |-> {1'b0, count_ff} + 5'(push_cnt) <= 5'(tddp_pkg::FIFO_DEPTH))
      else $error("push beyond free space");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && push_cnt == 2'd0 |=> count_ff == $past(count_ff) - tddp_pkg::CNT_W'(1))
      else $error("pop did not drain the queue");

endmodule

// ===== rtl/core/timestamp_delta_of_delta_packer.sv =====
// ----------------------------------------------------------------------------
// Timestamp delta-of-delta packer
// Packs a timestamp stream into 64-bit words of delta-of-delta codes.
//
//   Channel   Direction  Payload             Handshake
//   req_      in         command, timestamp  req_valid / req_ready
//   rsp_      out        word, last, trunc   rsp_valid / rsp_ready
//
// A request is registered in the encoder stage; the packer writes its words
// into the response queue when the queue has room, and the queue then offers
// its first word on rsp_valid.
// One request is accepted each cycle while the packer takes from the encoder.
// The packer holds a request while the eight-entry response queue has fewer
// than three free entries; a close can add three words in one cycle.
// Synchronous reset clears the history, the pending bits and the queue.
// ----------------------------------------------------------------------------
module timestamp_delta_of_delta_packer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tddp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tddp_pkg::rsp_type rsp_data
);

   logic              enc_valid;
   tddp_pkg::enc_type enc_data;
   logic              enc_take;
   logic              space_ok;
   logic [1:0]        push_cnt;
   tddp_pkg::rsp_type push_data [tddp_pkg::MAX_PUSH];

   // Encoder stage.
   tddp_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .enc_valid (enc_valid),
      .enc_data  (enc_data),
      .enc_take  (enc_take)
   );

   // Bit packer.
   tddp_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .enc_valid (enc_valid),
      .enc_data  (enc_data),
      .enc_take  (enc_take),
      .space_ok  (space_ok),
      .push_cnt  (push_cnt),
      .push_data (push_data)
   );

   // Response queue.
   tddp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_data (push_data),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/timestamp_delta_of_delta_packer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp delta-of-delta packer testbench
// Sends directed and random timestamp streams through the packer with random
// stalls on both channels. Every response is checked against words built
// bit by bit from a local copy of the timestamp history and the bit buffer.
// ----------------------------------------------------------------------------
module timestamp_delta_of_delta_packer_tb;

   // Command code that the packer ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Number of random requests to aim for.
   localparam int RANDOM_TARGET = 200;

   // One queued request with the idle time that follows it.
   typedef struct {
      tddp_pkg::req_type req;
      int unsigned       idle_after;
      bit                wait_drain;
   } timed_req_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   tddp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   tddp_pkg::rsp_type rsp_data;

   timed_req_type     pending_reqs[$];
   tddp_pkg::rsp_type expected_words[$];
   logic [63:0]       word_stage[$];

   // Local copy of the packer history and its partial word.
   logic [63:0] hist_ts;
   logic [63:0] hist_delta;
   logic [63:0] pend_bits;
   int          pend_fill;

   int unsigned words_predicted;
   int unsigned words_seen;
   int unsigned mismatch_count;
   int unsigned send_idle;
   int unsigned recv_idle;
   int unsigned recv_calm;
   bit          stim_done;

   timestamp_delta_of_delta_packer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Idle length: mostly none or short, sometimes long.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Number of significant bits of a value.
   function automatic int bit_length(input logic [63:0] v);
      int n;
      n = 0;
      while (v != 64'd0) begin
         n++;
         v = v >> 1;
      end
      return n;
   endfunction

   // Shift bits into the partial word, MSB first, staging every full word.
   task automatic append_bits(input logic [63:0] value, input int n);
      for (int i = n - 1; i >= 0; i--) begin
         pend_bits = {pend_bits[62:0], value[i]};
         pend_fill++;
         if (pend_fill == 64) begin
            word_stage.insert(word_stage.size(), pend_bits);
            pend_bits = '0;
            pend_fill = 0;
         end
      end
   endtask

   // Work out the words one accepted request produces and queue them.
   task automatic predict_request(input tddp_pkg::req_type r);
      logic [63:0] delta;
      logic [63:0] dod;
      logic [63:0] zz;
      int          len;
      bit          cut;
      cut = 1'b0;
      word_stage.delete();
      case (r.command)
         tddp_pkg::CMD_START: begin
            append_bits(r.timestamp, 64);
            hist_ts    = r.timestamp;
            hist_delta = '0;
         end
         tddp_pkg::CMD_NEXT: begin
            delta = r.timestamp - hist_ts;
            dod   = delta - hist_delta;
            if (dod == 64'd0) begin
               append_bits(64'd0, 1);
            end else begin
               // Zigzag folds the sign into the low bit.
               zz  = (dod << 1) ^ {64{dod[63]}};
               len = bit_length(zz);
               if (len <= 7) begin
                  append_bits({tddp_pkg::PFX_SHORT, zz[6:0]}, 9);
               end else if (len <= 9) begin
                  append_bits({tddp_pkg::PFX_MEDIUM, zz[8:0]}, 12);
               end else if (len <= 12) begin
                  append_bits({tddp_pkg::PFX_LONG, zz[11:0]}, 16);
               end else begin
                  append_bits(tddp_pkg::PFX_ESCAPE, 4);
                  append_bits(zz[31:0], 32);
                  cut = (zz[63:32] != 32'd0);
               end
            end
            hist_delta = delta;
            hist_ts    = r.timestamp;
         end
         tddp_pkg::CMD_CLOSE: begin
            append_bits(tddp_pkg::PFX_ESCAPE, 4);
            append_bits(64'hFFFF_FFFF, 32);
            append_bits(64'd0, 64);
            if (pend_fill > 0) begin
               word_stage.insert(word_stage.size(), pend_bits << (64 - pend_fill));
            end
            pend_bits = '0;
            pend_fill = 0;
         end
         default: begin
            // The unused command leaves everything as it is.
         end
      endcase
      for (int k = 0; k < word_stage.size(); k++) begin
         expected_words.insert(expected_words.size(),
                               tddp_pkg::rsp_type'{packed_word: word_stage[k],
                                                   last: (k == word_stage.size() - 1),
                                                   truncated: cut});
      end
      words_predicted += word_stage.size();
   endtask

   task automatic add_req(input logic [1:0] cmd, input logic [63:0] ts,
                          input int unsigned idle, input bit drain);
      timed_req_type t;
      t.req.command   = cmd;
      t.req.timestamp = ts;
      t.idle_after    = idle;
      t.wait_drain    = drain;
      pending_reqs.insert(pending_reqs.size(), t);
   endtask

   // Request driver: idles after a request for the idle time it carries, and holds a marked request
   // back until every response so far has been seen.
   always @(posedge clock) begin : driver
      timed_req_type t;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_idle = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_request(req_data);
         end
         if (!req_valid || req_ready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
               stim_done = 1'b1;
            end else if (pending_reqs[0].wait_drain && words_predicted != words_seen) begin
               req_valid <= 1'b0;
            end else begin
               t = pending_reqs.pop_front();
               req_data  <= t.req;
               req_valid <= 1'b1;
               send_idle = t.idle_after;
            end
         end
      end
   end

   // Response monitor and ready pattern with stalls and calm stretches.
   always @(posedge clock) begin : monitor
      tddp_pkg::rsp_type want;
      bit                bad;
      int unsigned       pick;
      if (reset) begin
         rsp_ready  <= 1'b0;
         words_seen <= 0;
         recv_idle = 0;
         recv_calm = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_seen <= words_seen + 1;
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected response: word %h last %b truncated %b",
                           rsp_data.packed_word, rsp_data.last, rsp_data.truncated);
               end
            end else begin
               want = expected_words.pop_front();
               bad = (rsp_data.packed_word !== want.packed_word) ||
                     (rsp_data.last !== want.last) ||
                     (rsp_data.truncated !== want.truncated);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: expected word %h last %b truncated %b,",
                              want.packed_word, want.last, want.truncated,
                              " got word %h last %b truncated %b",
                              rsp_data.packed_word, rsp_data.last, rsp_data.truncated);
                  end
               end
            end
         end
         if (recv_calm > 0) begin
            recv_calm--;
            rsp_ready <= 1'b1;
         end else if (recv_idle > 0) begin
            recv_idle--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               recv_calm = $urandom_range(50, 200);
            end else if (pick < 35) begin
               recv_idle = idle_len();
            end
         end
      end
   end

   // Stimulus, then the end of the run.
   initial begin : stimulus
      logic [63:0] ts;
      logic [63:0] interval;
      longint      jitter;
      int          count;
      int          random_count;
      bit          burst;
      int unsigned r;

      hist_ts         = '0;
      hist_delta      = '0;
      pend_bits       = '0;
      pend_fill       = 0;
      words_predicted = 0;
      words_seen      = 0;
      mismatch_count  = 0;
      stim_done       = 1'b0;

      // Directed: every code length, escape with and without a cut value,
      // a cut value that completes no word, wraparound, the unused command,
      // a start in the middle of a stream and closes at different fills.
      add_req(tddp_pkg::CMD_START, 64'd0, 0, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'd0, 0, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'd1, 1, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'd1, 0, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'd101, 0, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'd1201, 2, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'd1201 + 64'd1100 + 64'h1_0000, 0, 1'b0);
      add_req(tddp_pkg::CMD_CLOSE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
      add_req(tddp_pkg::CMD_START, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'd0, 0, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'h0000_0100_0000_0001, 0, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'h8000_0000_0000_0000, 3, 1'b0);
      add_req(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
      add_req(tddp_pkg::CMD_START, 64'hA5A5_5A5A_C3C3_3C3C, 0, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'hA5A5_5A5A_C3C3_3C3C - 64'd1, 0, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'h5A5A_A5A5_3C3C_C3C3, 0, 1'b0);
      add_req(tddp_pkg::CMD_CLOSE, 64'd0, 0, 1'b1);
      add_req(tddp_pkg::CMD_CLOSE, 64'd0, 0, 1'b0);
      add_req(CMD_UNUSED, 64'd0, 0, 1'b0);
      add_req(tddp_pkg::CMD_NEXT, 64'd0, 0, 1'b0);
      add_req(tddp_pkg::CMD_CLOSE, 64'd0, 5, 1'b0);

      // Random: mostly well-formed streams with jittered intervals.
      random_count = 0;
      while (random_count < RANDOM_TARGET) begin
         burst    = ($urandom_range(0, 3) == 0);
         ts       = {$urandom, $urandom};
         interval = (($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                                 : 64'($urandom_range(1, 1000)));
         count    = $urandom_range(3, 30);
         add_req(tddp_pkg::CMD_START, ts, burst ? 0 : idle_len(),
                 ($urandom_range(0, 5) == 0));
         random_count++;
         for (int i = 0; i < count && random_count < RANDOM_TARGET; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               jitter = 0;
            end else if (r < 70) begin
               jitter = $urandom_range(1, 60);
            end else if (r < 85) begin
               jitter = $urandom_range(64, 255);
            end else if (r < 95) begin
               jitter = $urandom_range(256, 2047);
            end else begin
               jitter = longint'({$urandom, $urandom});
            end
            if ($urandom_range(0, 1) == 1) begin
               jitter = -jitter;
            end
            ts = ts + interval + 64'(jitter);
            r = $urandom_range(0, 99);
            if (r < 3) begin
               add_req(CMD_UNUSED, {$urandom, $urandom}, burst ? 0 : idle_len(), 1'b0);
            end else if (r < 6) begin
               add_req(tddp_pkg::CMD_START, {$urandom, $urandom},
                       burst ? 0 : idle_len(), 1'b0);
               random_count++;
            end else if (r < 9) begin
               add_req(tddp_pkg::CMD_NEXT, {$urandom, $urandom},
                       burst ? 0 : idle_len(), 1'b0);
               random_count++;
            end
            add_req(tddp_pkg::CMD_NEXT, ts, burst ? 0 : idle_len(), 1'b0);
            random_count++;
         end
         if ($urandom_range(0, 99) < 85) begin
            add_req(tddp_pkg::CMD_CLOSE, {$urandom, $urandom},
                    burst ? 0 : idle_len(), 1'b0);
            random_count++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (stim_done);
      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);

      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Run limit.
   initial begin : watchdog
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
